// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define AST_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define AST_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== hw/rtl/ada_pkg.sv =====
// ----------------------------------------------------------------------------
// ada_pkg
// Shared widths, register indexes, defaults and helpers of the area downscaler.
// ----------------------------------------------------------------------------
package ada_pkg;

  localparam int REG_W   = 11;
  localparam int CCNT_W  = 3;
  localparam int PIX_W   = 8;
  localparam int SUM_W   = 28;
  localparam int QUO_W   = 8;
  localparam int FLD_CH  = 4;
  localparam int TILE_W  = 10;
  localparam int IDX_W   = 3;

  localparam int DEF_MAX_WIDTH    = 1024;
  localparam int DEF_MAX_HEIGHT   = 1024;
  localparam int DEF_MAX_CHANNELS = 4;

  localparam logic [IDX_W-1:0] REG_SRC_WIDTH  = 3'd0;
  localparam logic [IDX_W-1:0] REG_SRC_HEIGHT = 3'd1;
  localparam logic [IDX_W-1:0] REG_TGT_WIDTH  = 3'd2;
  localparam logic [IDX_W-1:0] REG_TGT_HEIGHT = 3'd3;
  localparam logic [IDX_W-1:0] REG_CHANNELS   = 3'd4;

  localparam logic [REG_W-1:0]  RST_SRC_WIDTH  = 11'd640;
  localparam logic [REG_W-1:0]  RST_SRC_HEIGHT = 11'd480;
  localparam logic [REG_W-1:0]  RST_TGT_WIDTH  = 11'd160;
  localparam logic [REG_W-1:0]  RST_TGT_HEIGHT = 11'd120;
  localparam logic [CCNT_W-1:0] RST_CHANNELS   = 3'd3;

  // Per-transaction control handed to every channel lane.
  typedef struct packed {
    logic             rd;
    logic             wr;
    logic             first;
    logic             step;
    logic [2:0]       bit_idx;
  } lane_ctrl_t;

  function automatic logic [15:0] clamp_u(input logic [15:0] v, input logic [15:0] lo,
                                          input logic [15:0] hi);
    logic [15:0] r;
    r = v;
    if (v < lo) r = lo;
    else if (v > hi) r = hi;
    return r;
  endfunction

endpackage

// ===== hw/rtl/ada_lane.sv =====
// ----------------------------------------------------------------------------
// ada_lane
// One channel lane: column sum memory, accumulate, and restoring divider.
// ----------------------------------------------------------------------------
module ada_lane #(
  parameter int MAX_WIDTH = ada_pkg::DEF_MAX_WIDTH,
  parameter int CNT_W     = 24
) (
  input  logic                          clk,
  input  ada_pkg::lane_ctrl_t           ctrl,
  input  logic [$clog2(MAX_WIDTH)-1:0]  addr,
  input  logic [ada_pkg::PIX_W-1:0]     px,
  input  logic [CNT_W-1:0]              count,
  output logic [ada_pkg::QUO_W-1:0]     quot
);

  localparam int DIV_W = CNT_W + ada_pkg::QUO_W;
  localparam int RW    = (DIV_W > ada_pkg::SUM_W) ? DIV_W : ada_pkg::SUM_W;

  logic [ada_pkg::SUM_W-1:0] mem [MAX_WIDTH];
  logic [ada_pkg::SUM_W-1:0] rdata_r;
  logic [ada_pkg::SUM_W-1:0] sum_nxt;
  logic [RW-1:0]             rem_r;
  logic [RW-1:0]             dvs;
  logic [ada_pkg::QUO_W-1:0] quot_r;

  // First pixel of a tile overwrites the stale sum.
  assign sum_nxt = ctrl.first ? ada_pkg::SUM_W'(px)
                              : rdata_r + ada_pkg::SUM_W'(px);
  assign dvs     = RW'(count) << ctrl.bit_idx;

  always_ff @(posedge clk) begin
    if (ctrl.rd) rdata_r <= mem[addr];
    if (ctrl.wr) mem[addr] <= sum_nxt;
  end

  always_ff @(posedge clk) begin
    if (ctrl.wr) begin
      rem_r  <= RW'(sum_nxt);
      quot_r <= '0;
    end else if (ctrl.step) begin
      if (rem_r >= dvs) begin
        rem_r <= rem_r - dvs;
        quot_r[ctrl.bit_idx] <= 1'b1;
      end
    end
  end

  assign quot = quot_r;

endmodule

// ===== hw/rtl/area_average_image_downscale.sv =====
// Sequence: each accepted pixel passes S_RD (column sum read) and S_ACC (writeback); a
//   tile-closing pixel then runs the S_DIV divider steps and the S_PUSH output load, which may stall.
// Only one pixel is in flight: in_tready is high in S_IDLE alone, so the column sum
//   read-modify-write and the one-bit-per-cycle divider finish before the next accept.
// Reset (rst_n low, synchronous): registers return to 640x480 -> 160x120, 3 channels,
//   frame position clears; sum memories are not cleared (first tile row overwrites).
// ----------------------------------------------------------------------------
// area_average_image_downscale
// Box-filter downscaler: per-channel lanes accumulate column sums and divide.
// ----------------------------------------------------------------------------
module area_average_image_downscale #(
  parameter int MAX_WIDTH    = ada_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT   = ada_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_CHANNELS = ada_pkg::DEF_MAX_CHANNELS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [31:0]                 in_tdata,   // chan0_in, chan1_in, chan2_in, chan3_in
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // chan0_avg, chan1_avg, chan2_avg, chan3_avg, tile_column, tile_row, 4'b0 pad
  output logic [55:0]                 out_tdata,
  output logic                        out_tlast,  // frame_done
  input  logic                        cfg_we,
  input  logic [ada_pkg::IDX_W-1:0]   cfg_addr,
  input  logic [ada_pkg::REG_W-1:0]   cfg_wdata
);

  localparam int AW    = $clog2(MAX_WIDTH);
  localparam int CW    = $clog2(MAX_WIDTH + 1);
  localparam int HA    = $clog2(MAX_HEIGHT);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);
  localparam int CDW   = CW + 3;
  localparam int RDW   = HW + 3;
  localparam int CNT_W = CW + HW;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_ACC  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_PUSH = 3'd4;

  // configuration
  logic [ada_pkg::REG_W-1:0]  sw_raw_r, sh_raw_r, tw_raw_r, th_raw_r;
  logic [ada_pkg::CCNT_W-1:0] nch_raw_r;
  logic [CW-1:0] sw, tw;
  logic [HW-1:0] sh, th;
  logic [ada_pkg::CCNT_W-1:0] nch;

  assign sw  = CW'(ada_pkg::clamp_u(16'(sw_raw_r), 16'd1, 16'(MAX_WIDTH)));
  assign sh  = HW'(ada_pkg::clamp_u(16'(sh_raw_r), 16'd1, 16'(MAX_HEIGHT)));
  assign tw  = CW'(ada_pkg::clamp_u(16'(tw_raw_r), 16'd1, 16'(sw)));
  assign th  = HW'(ada_pkg::clamp_u(16'(th_raw_r), 16'd1, 16'(sh)));
  assign nch = ada_pkg::CCNT_W'(ada_pkg::clamp_u(16'(nch_raw_r), 16'd1,
                                                 16'(MAX_CHANNELS)));

  // position state
  logic [CW-1:0]  src_col_r;
  logic [HW-1:0]  src_row_r;
  logic [AW-1:0]  out_col_r, col_cnt_r;
  logic [HA-1:0]  out_row_r, row_cnt_r;
  logic signed [CDW-1:0] col_d_r;
  logic signed [RDW-1:0] row_d_r;

  logic signed [CDW-1:0] sw_s, tw_s, col_init, col_dv;
  logic signed [RDW-1:0] sh_s, th_s, row_init, row_dv;
  logic col_end, row_end, row_last, frame_last, in_acc;

  assign sw_s = CDW'(sw);
  assign tw_s = CDW'(tw);
  assign sh_s = RDW'(sh);
  assign th_s = RDW'(th);
  // Tile ends when (pos+2)*out - (tile+1)*src >= 1.
  assign col_init = (tw_s <<< 1) - sw_s;
  assign row_init = (th_s <<< 1) - sh_s;
  assign col_dv   = (src_col_r == '0) ? col_init : col_d_r;
  assign row_dv   = (src_row_r == '0) ? row_init : row_d_r;
  assign col_end  = col_dv > 0;
  assign row_end  = row_dv > 0;
  assign row_last   = (src_col_r + CW'(1)) == sw;
  assign frame_last = (src_row_r + HW'(1)) == sh;

  // FSM and transaction registers
  logic [2:0] state_r;
  logic [2:0] bit_idx_r;
  logic [AW-1:0] addr_r;
  logic [ada_pkg::PIX_W-1:0] px_r [MAX_CHANNELS];
  logic first_r, emit_r, done_r;
  logic [AW-1:0] tcol_r;
  logic [HA-1:0] trow_r;
  logic [CW-1:0] w_r;
  logic [HW-1:0] h_r;
  logic [CNT_W-1:0] count_r;
  logic out_valid_r, out_last_r;
  logic [55:0] out_data_r;
  logic [55:0] out_data_nxt;
  logic load_out;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign load_out  = (state_r == S_PUSH) && (!out_valid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sw_raw_r  <= ada_pkg::RST_SRC_WIDTH;
      sh_raw_r  <= ada_pkg::RST_SRC_HEIGHT;
      tw_raw_r  <= ada_pkg::RST_TGT_WIDTH;
      th_raw_r  <= ada_pkg::RST_TGT_HEIGHT;
      nch_raw_r <= ada_pkg::RST_CHANNELS;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        ada_pkg::REG_SRC_WIDTH:  sw_raw_r  <= cfg_wdata;
        ada_pkg::REG_SRC_HEIGHT: sh_raw_r  <= cfg_wdata;
        ada_pkg::REG_TGT_WIDTH:  tw_raw_r  <= cfg_wdata;
        ada_pkg::REG_TGT_HEIGHT: th_raw_r  <= cfg_wdata;
        ada_pkg::REG_CHANNELS:   nch_raw_r <= cfg_wdata[ada_pkg::CCNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (cfg_we && cfg_addr <= ada_pkg::REG_CHANNELS)) begin
      src_col_r <= '0;
      src_row_r <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
      col_cnt_r <= '0;
      row_cnt_r <= '0;
    end else if (in_acc) begin
      if (row_last) begin
        src_col_r <= '0;
        out_col_r <= '0;
        col_cnt_r <= '0;
        if (frame_last) begin
          src_row_r <= '0;
          out_row_r <= '0;
          row_cnt_r <= '0;
        end else begin
          src_row_r <= src_row_r + HW'(1);
          if (row_end) begin
            out_row_r <= out_row_r + HA'(1);
            row_cnt_r <= '0;
            row_d_r   <= row_dv + th_s - sh_s;
          end else begin
            row_cnt_r <= row_cnt_r + HA'(1);
            row_d_r   <= row_dv + th_s;
          end
        end
      end else begin
        src_col_r <= src_col_r + CW'(1);
        if (col_end) begin
          out_col_r <= out_col_r + AW'(1);
          col_cnt_r <= '0;
          col_d_r   <= col_dv + tw_s - sw_s;
        end else begin
          col_cnt_r <= col_cnt_r + AW'(1);
          col_d_r   <= col_dv + tw_s;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      addr_r  <= out_col_r;
      first_r <= (col_cnt_r == '0) && (row_cnt_r == '0);
      emit_r  <= col_end && row_end;
      tcol_r  <= out_col_r;
      trow_r  <= out_row_r;
      done_r  <= ((CW'(out_col_r) + CW'(1)) == tw) && ((HW'(out_row_r) + HW'(1)) == th);
      w_r     <= CW'(col_cnt_r) + CW'(1);
      h_r     <= HW'(row_cnt_r) + HW'(1);
    end
    if (state_r == S_RD) count_r <= CNT_W'(w_r) * CNT_W'(h_r);
  end

  for (genvar c = 0; c < MAX_CHANNELS; c++) begin : g_px
    always_ff @(posedge clk) begin
      if (in_acc) px_r[c] <= in_tdata[8*c +: 8];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      bit_idx_r <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: if (in_acc) state_r <= S_RD;
        S_RD:   state_r <= S_ACC;
        S_ACC: begin
          bit_idx_r <= 3'd7;
          state_r   <= emit_r ? S_DIV : S_IDLE;
        end
        S_DIV: begin
          if (bit_idx_r == 3'd0) state_r <= S_PUSH;
          bit_idx_r <= bit_idx_r - 3'd1;
        end
        S_PUSH: if (load_out) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // lanes
  ada_pkg::lane_ctrl_t lctrl;
  logic [ada_pkg::QUO_W-1:0] quot [MAX_CHANNELS];
  logic [ada_pkg::QUO_W-1:0] avg  [ada_pkg::FLD_CH];

  assign lctrl.rd      = (state_r == S_RD);
  assign lctrl.wr      = (state_r == S_ACC);
  assign lctrl.first   = first_r;
  assign lctrl.step    = (state_r == S_DIV);
  assign lctrl.bit_idx = bit_idx_r;

  for (genvar c = 0; c < MAX_CHANNELS; c++) begin : g_lane
    ada_lane #(
      .MAX_WIDTH (MAX_WIDTH),
      .CNT_W     (CNT_W)
    ) u_lane (
      .clk   (clk),
      .ctrl  (lctrl),
      .addr  (addr_r),
      .px    (px_r[c]),
      .count (count_r),
      .quot  (quot[c])
    );
  end

  // merge: mask idle channels and pack the result
  for (genvar c = 0; c < ada_pkg::FLD_CH; c++) begin : g_avg
    if (c < MAX_CHANNELS) begin : g_on
      assign avg[c] = (nch > ada_pkg::CCNT_W'(c)) ? quot[c] : '0;
    end else begin : g_off
      assign avg[c] = '0;
    end
  end

  logic [31:0] tcol_ext, trow_ext;
  assign tcol_ext = 32'(tcol_r);
  assign trow_ext = 32'(trow_r);
  assign out_data_nxt = {4'b0, trow_ext[ada_pkg::TILE_W-1:0], tcol_ext[ada_pkg::TILE_W-1:0],
                         avg[3], avg[2], avg[1], avg[0]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data_r <= out_data_nxt;
      out_last_r <= done_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

// ===== hw/rtl/ada_checker.sv =====
// ----------------------------------------------------------------------------
// ada_checker
// Port-level checks of the area downscaler, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ada_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [55:0] out_tdata,
  input logic        out_tlast
);

  logic in_acc;
  assign in_acc = in_tvalid && in_tready;

  `AST_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast))
  `AST_NEXT(a_one_in_flight, in_acc, !in_tready)
  `AST_IMPLY(a_pad_zero, out_tvalid, out_tdata[55:52] == 4'b0)

endmodule

bind area_average_image_downscale ada_checker u_ada_checker (.*);

// ===== tb/sv/tb_area_average_image_downscale.sv =====
// ----------------------------------------------------------------------------
// tb_area_average_image_downscale
// Streams source frames of many shapes and configurations through the area
// downscaler, predicts every averaged tile and checks each output field.
// ----------------------------------------------------------------------------
module tb_area_average_image_downscale;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int SETTLE_CYCLES  = 40;
  localparam int PRESSURE_HOLD  = 400;
  localparam int SUM_DEPTH      = ada_pkg::DEF_MAX_WIDTH * ada_pkg::DEF_MAX_CHANNELS;

  typedef struct packed {
    logic                           done;
    logic [ada_pkg::TILE_W-1:0]     row;
    logic [ada_pkg::TILE_W-1:0]     col;
    logic [3:0][ada_pkg::PIX_W-1:0] avg;
  } tile_result_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_tvalid = 1'b0;
  logic                      in_tready;
  logic [31:0]               in_tdata = '0;    // chan0_in, chan1_in, chan2_in, chan3_in
  logic                      out_tvalid;
  logic                      out_tready = 1'b1;
  // chan0_avg, chan1_avg, chan2_avg, chan3_avg, tile_column, tile_row, pad
  logic [55:0]               out_tdata;
  logic                      out_tlast;        // frame_done
  logic                      cfg_we = 1'b0;
  logic [ada_pkg::IDX_W-1:0] cfg_addr = '0;
  logic [ada_pkg::REG_W-1:0] cfg_wdata = '0;

  always #5 clk = ~clk;

  area_average_image_downscale u_top (.*);

  // Predictor state
  int unsigned  reg_sw, reg_sh, reg_tw, reg_th, reg_ch;
  logic [ada_pkg::SUM_W-1:0] col_sum [SUM_DEPTH];
  int unsigned  src_col, src_row, tile_col, tile_row, col_end, row_end, col_begin, row_begin;
  tile_result_t pending_tiles[$];

  int  errors = 0;
  int  pixels_sent = 0;
  int  tiles_checked = 0;
  int  frames_sent = 0;
  bit  idle_en = 1'b1;
  bit  pressure_req = 1'b0;
  int  stall_left = 0;
  int  quiet_cycles = 0;

  function automatic int unsigned clip(int unsigned v, int unsigned lo, int unsigned hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic int unsigned eff_w();
    return clip(reg_sw, 1, ada_pkg::DEF_MAX_WIDTH);
  endfunction
  function automatic int unsigned eff_h();
    return clip(reg_sh, 1, ada_pkg::DEF_MAX_HEIGHT);
  endfunction
  function automatic int unsigned eff_tw(); return clip(reg_tw, 1, eff_w()); endfunction
  function automatic int unsigned eff_th(); return clip(reg_th, 1, eff_h()); endfunction
  function automatic int unsigned eff_ch();
    return clip(reg_ch, 1, ada_pkg::DEF_MAX_CHANNELS);
  endfunction

  function automatic int unsigned tile_bound(int unsigned i, int unsigned src, int unsigned n);
    longint unsigned p;
    p = longint'(i + 1) * src;
    return int'(p / n);
  endfunction

  function automatic void frame_restart();
    src_col = 0; src_row = 0; tile_col = 0; tile_row = 0;
    col_begin = 0; row_begin = 0;
    col_end = tile_bound(0, eff_w(), eff_tw());
    row_end = tile_bound(0, eff_h(), eff_th());
  endfunction

  // Accumulate one accepted pixel and queue the tile it closes, if any.
  function automatic void accumulate_pixel(logic [31:0] px);
    int unsigned  nch, base, cnt;
    bit           first_row;
    tile_result_t t;
    nch = eff_ch();
    first_row = (src_row == row_begin);
    base = (tile_col % ada_pkg::DEF_MAX_WIDTH) * ada_pkg::DEF_MAX_CHANNELS;
    for (int c = 0; c < nch; c++) begin
      if (first_row && src_col == col_begin)
        col_sum[base+c] = ada_pkg::SUM_W'(px[8*c +: 8]);
      else
        col_sum[base+c] = col_sum[base+c] + ada_pkg::SUM_W'(px[8*c +: 8]);
    end
    if (src_row + 1 == row_end && src_col + 1 == col_end) begin
      cnt = (col_end - col_begin) * (row_end - row_begin);
      if (cnt == 0) cnt = 1;
      for (int c = 0; c < 4; c++)
        t.avg[c] = (c < nch) ? ada_pkg::PIX_W'(col_sum[base+c] / cnt) : '0;
      t.col = ada_pkg::TILE_W'(tile_col);
      t.row = ada_pkg::TILE_W'(tile_row);
      t.done = (tile_col + 1 == eff_tw() && tile_row + 1 == eff_th());
      pending_tiles.push_back(t);
    end
    src_col++;
    if (src_col >= col_end) begin
      tile_col++;
      col_begin = col_end;
      col_end = tile_bound(tile_col, eff_w(), eff_tw());
    end
    if (src_col >= eff_w()) begin
      src_col = 0; tile_col = 0; col_begin = 0;
      col_end = tile_bound(0, eff_w(), eff_tw());
      src_row++;
      if (src_row >= row_end) begin
        tile_row++;
        row_begin = row_end;
        row_end = tile_bound(tile_row, eff_h(), eff_th());
      end
      if (src_row >= eff_h()) frame_restart();
    end
  endfunction

  task automatic report(string what, int got, int want);
    $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // Result checker
  always @(posedge clk) begin
    tile_result_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tlast, out_tdata[51:42], out_tdata[41:32], out_tdata[31:0]};
      if (pending_tiles.size() == 0) begin
        report("unexpected tile, column", got.col, -1);
      end else begin
        want = pending_tiles.pop_front();
        for (int c = 0; c < 4; c++)
          if (got.avg[c] !== want.avg[c])
            report($sformatf("chan%0d_avg", c), got.avg[c], want.avg[c]);
        if (got.col !== want.col) report("tile_column", got.col, want.col);
        if (got.row !== want.row) report("tile_row", got.row, want.row);
        if (got.done !== want.done) report("frame_done", got.done, want.done);
        tiles_checked++;
      end
    end
  end

  // Receiver: random stall bursts, plus one long hold when asked
  initial begin
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        stall_left--;
        if (stall_left == 0) out_tready <= 1'b1;
      end else if (pressure_req) begin
        pressure_req = 1'b0;
        out_tready <= 1'b0;
        stall_left = PRESSURE_HOLD;
      end else if (idle_en && $urandom_range(0, 9) == 0) begin
        out_tready <= 1'b0;
        stall_left = $urandom_range(1, 15);
      end
    end
  end

  // Watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired after %0d quiet cycles", quiet_cycles);
      $display("FAILURE");
      $finish;
    end
  end

  // Write all five registers back to back; every write restarts the frame.
  task automatic program_frame(int unsigned w, int unsigned h, int unsigned tw,
                               int unsigned th, int unsigned ch);
    logic [ada_pkg::REG_W-1:0] vals [5];
    logic [ada_pkg::IDX_W-1:0] idx  [5];
    vals = '{ada_pkg::REG_W'(w), ada_pkg::REG_W'(h), ada_pkg::REG_W'(tw),
             ada_pkg::REG_W'(th), ada_pkg::REG_W'(ch)};
    idx  = '{ada_pkg::REG_SRC_WIDTH, ada_pkg::REG_SRC_HEIGHT, ada_pkg::REG_TGT_WIDTH,
             ada_pkg::REG_TGT_HEIGHT, ada_pkg::REG_CHANNELS};
    for (int i = 0; i < 5; i++) begin
      cfg_we <= 1'b1;
      cfg_addr <= idx[i];
      cfg_wdata <= vals[i];
      @(posedge clk);
      case (idx[i])
        ada_pkg::REG_SRC_WIDTH:  reg_sw = vals[i];
        ada_pkg::REG_SRC_HEIGHT: reg_sh = vals[i];
        ada_pkg::REG_TGT_WIDTH:  reg_tw = vals[i];
        ada_pkg::REG_TGT_HEIGHT: reg_th = vals[i];
        ada_pkg::REG_CHANNELS:   reg_ch = vals[i] & 3'h7;
        default: ;
      endcase
      frame_restart();
    end
    cfg_we <= 1'b0;
  endtask

  task automatic send_pixel(logic [31:0] px);
    if (idle_en && $urandom_range(0, 7) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= px;
    do @(posedge clk); while (!in_tready);
    accumulate_pixel(px);
    pixels_sent++;
  endtask

  // fill < 0 gives random bytes, otherwise every byte is fill
  task automatic send_pixels(int n, int fill);
    for (int i = 0; i < n; i++)
      send_pixel(fill < 0 ? $urandom : {4{fill[7:0]}});
    frames_sent++;
  endtask

  // Drop valid, let all tiles arrive, then give the divider time to settle.
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_tiles.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic test_small_tiles();
    program_frame(4, 2, 2, 1, 4);
    send_pixel(32'hFFFF_FFFF); send_pixel(32'h0000_0000);
    send_pixel(32'hFFFF_FFFF); send_pixel(32'h0102_0304);
    send_pixel(32'hFFFF_FFFF); send_pixel(32'h8080_8080);
    send_pixel(32'h0000_0000); send_pixel(32'hFFFF_FFFF);
    drain();
    // uneven tiles, single channel so upper averages read zero
    program_frame(3, 3, 2, 2, 1);
    send_pixels(9, -1);
    drain();
  endtask

  task automatic test_clamped_registers();
    program_frame(0, 0, 0, 0, 0);
    send_pixels(3, 255);
    drain();
    program_frame(5, 2, 2047, 2047, 5);
    send_pixels(10, -1);
    drain();
  endtask

  task automatic test_largest_frames();
    // full-width row, one tile per pixel; only its start is streamed
    program_frame(2047, 0, 2047, 5, 7);
    send_pixels(64, -1);
    drain();
    // wide tile along a full-width row and tall tile down a full-height column
    program_frame(1024, 1, 8, 1, 4);
    send_pixels(128, 255);
    drain();
    program_frame(1, 1024, 1, 8, 6);
    send_pixels(128, 255);
    drain();
  endtask

  task automatic test_restart_mid_frame();
    program_frame(6, 4, 3, 2, 3);
    send_pixels(9, -1);
    drain();
    program_frame(6, 4, 3, 2, 2);
    send_pixels(24, -1);
    drain();
  endtask

  task automatic test_backpressure();
    program_frame(16, 8, 16, 8, 4);
    pressure_req = 1'b1;
    send_pixels(128, -1);
    drain();
  endtask

  task automatic random_frame();
    int unsigned w, h, n;
    w = $urandom_range(1, 24);
    h = $urandom_range(1, 8);
    program_frame(w, h, $urandom_range(0, w + 3), $urandom_range(0, h + 3),
                  $urandom_range(0, 7));
    n = w * h;
    if ($urandom_range(0, 9) == 0) n = $urandom_range(1, n);
    send_pixels(n, -1);
    drain();
  endtask

  task automatic test_random_frames();
    int unsigned stop_at;
    stop_at = pixels_sent + 150;
    while (pixels_sent < stop_at) random_frame();
  endtask

  task automatic test_no_idle();
    idle_en = 1'b0;
    @(posedge clk);
    while (stall_left != 0) @(posedge clk);
    repeat (3) random_frame();
  endtask

  initial begin
    reg_sw = ada_pkg::RST_SRC_WIDTH; reg_sh = ada_pkg::RST_SRC_HEIGHT;
    reg_tw = ada_pkg::RST_TGT_WIDTH; reg_th = ada_pkg::RST_TGT_HEIGHT;
    reg_ch = ada_pkg::RST_CHANNELS;
    frame_restart();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_small_tiles();
    test_clamped_registers();
    test_restart_mid_frame();
    test_backpressure();
    test_largest_frames();
    test_random_frames();
    test_no_idle();
    $display("covered %0d source pixels in %0d frames, %0d averaged tiles checked",
             pixels_sent, frames_sent, tiles_checked);
    $display("shapes from 1x1 to 1024 wide/tall, clamped registers, long output stall");
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches", errors);
      $display("FAILURE");
    end
    $finish;
  end

endmodule
